// File: rtl/core/cmd3_pkg.sv
package cmd3_pkg;

  localparam int unsigned PosBits  = 24;
  localparam int unsigned IdxBits  = 18;
  localparam int unsigned AccBits  = 32;
  localparam int unsigned CfgAddrBits = 2;
  localparam int unsigned CfgDataBits = 24;

  typedef enum logic [CfgAddrBits-1:0] {
    CfgOriginX = 2'd0,
    CfgOriginY = 2'd1,
    CfgOriginZ = 2'd2,
    CfgLevel   = 2'd3
  } cfg_reg_e;

  localparam logic OpDeposit = 1'b0;
  localparam logic OpRead    = 1'b1;

endpackage

// File: rtl/core/cmd3_ram.sv
module cmd3_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: rtl/core/cic_mass_deposit_3d_core.sv
// Channel   Dir  Handshake                 Contents
// cfg       in   cfg_valid_i/cfg_ready_o   register index and write data
// s_axis    in   s_axis_tvalid/tready      one word per deposit or read
// m_axis    out  m_axis_tvalid/tready      one word per read
//
// After reset the block sweeps the grid memory to zero, one cell per cycle;
// no word is accepted until then. A deposit splits the position and forms
// the weights in StSplit, StWy and StWz, then makes eight corner accumulations
// through the single grid memory, each a read followed by a write in the next
// cycle. A read passes through StRdWait to StOut, where the output word waits
// for m_axis_tready.
module cic_mass_deposit_3d_core #(
  parameter int unsigned MAX_LEVEL        = 6,
  parameter int unsigned WEIGHT_FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [0] operation, [24:1] pos_x, [48:25] pos_y, [72:49] pos_z,
  // [90:73] read_index, [95:91] zero
  input  logic [95:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [17:0] cell_index, [49:18] density, [50] saturated, [55:51] zero
  output logic [55:0] m_axis_tdata
);
  import cmd3_pkg::*;

  localparam int unsigned GridBits = 3 * MAX_LEVEL;
  localparam int unsigned Cells    = 1 << GridBits;
  localparam int unsigned WB       = WEIGHT_FRAC_BITS + 1;
  localparam int unsigned LvlBits  = $clog2(MAX_LEVEL + 1);
  localparam logic [WB-1:0] OneW   = WB'(1) << WEIGHT_FRAC_BITS;
  localparam logic [2*WB-1:0] Half = (2*WB)'(1) << (WEIGHT_FRAC_BITS - 1);
  localparam logic [AccBits-1:0] AccMax = '1;

  typedef enum logic [2:0] {
    StClear, StIdle, StSplit, StWy, StWz, StAcc, StRdWait, StOut
  } state_e;

  state_e state_q;
  logic [GridBits-1:0] clr_q;
  logic [23:0] org_x_q, org_y_q, org_z_q;
  logic [2:0] level_q;
  logic [95:0] item_q;
  logic [LvlBits-1:0] lev_q;
  logic [MAX_LEVEL-1:0] cx_q, cy_q, cz_q;
  logic [WB-1:0] dx_q, dy_q, dz_q;
  logic [WB-1:0] wy_q [4];   // index {i,j}
  logic [WB-1:0] wz_q [8];   // index {i,j,k}
  logic [2:0] corner_q;
  logic wr_pend_q;
  logic [GridBits-1:0] wr_addr_q;
  logic [WB-1:0] wr_w_q;
  logic [IdxBits-1:0] rd_idx_q;
  logic rd_fwd_q;
  logic [55:0] out_q;

  // Level clamp.
  logic [LvlBits-1:0] lev_use;
  always_comb begin
    if (level_q == 3'd0) lev_use = LvlBits'(1);
    else if (32'(level_q) > MAX_LEVEL) lev_use = LvlBits'(MAX_LEVEL);
    else lev_use = LvlBits'(level_q);
  end

  function automatic void split(input logic [23:0] p, input logic [23:0] o,
                                input logic [LvlBits-1:0] l,
                                output logic [MAX_LEVEL-1:0] c,
                                output logic [WB-1:0] d);
    logic [23:0] rel;
    logic [47:0] ext;
    rel = p - o;
    c = MAX_LEVEL'(rel >> (24 - 32'(l)));
    // Shift the sub-cell bits up to the top, then keep the fraction bits.
    ext = {rel << l, 24'd0};
    d = WB'(ext[47 -: WEIGHT_FRAC_BITS]);
  endfunction

  function automatic logic [WB-1:0] part_of(input logic [WB-1:0] w,
                                            input logic [WB-1:0] t);
    logic [2*WB-1:0] pr;
    pr = (2*WB)'(w) * (2*WB)'(t) + Half;
    return WB'(pr >> WEIGHT_FRAC_BITS);
  endfunction

  // Corner address.
  logic [MAX_LEVEL-1:0] lmask, xi, yj, zk;
  logic [GridBits-1:0] c_addr;
  always_comb begin
    lmask = MAX_LEVEL'((1 << lev_q) - 1);
    xi = (cx_q + MAX_LEVEL'(corner_q[2])) & lmask;
    yj = (cy_q + MAX_LEVEL'(corner_q[1])) & lmask;
    zk = (cz_q + MAX_LEVEL'(corner_q[0])) & lmask;
    c_addr = GridBits'(xi) | (GridBits'(yj) << lev_q) | (GridBits'(zk) << (2 * lev_q));
  end

  // Read index wrap.
  logic [GridBits-1:0] rd_mask, rd_addr;
  assign rd_mask = GridBits'((64'd1 << (3 * lev_use)) - 64'd1);
  assign rd_addr = GridBits'(s_axis_tdata[90:73]) & rd_mask;

  // Memory with write forwarding: the previous corner may be the same cell.
  logic mem_we;
  logic [GridBits-1:0] mem_waddr, mem_raddr;
  logic [AccBits-1:0] mem_wdata, mem_rdata, acc_old, rd_data;
  logic [AccBits:0] acc_sum;
  logic fwd_q, fwd_d;
  logic [AccBits-1:0] last_wdata_q;

  assign acc_old = fwd_q ? last_wdata_q : mem_rdata;
  assign acc_sum = {1'b0, acc_old} + (AccBits+1)'(wr_w_q);
  // A read accepted while the last corner is written sees the old cell in
  // memory, so it takes the written word instead.
  assign rd_data = rd_fwd_q ? last_wdata_q : mem_rdata;

  always_comb begin
    mem_we = 1'b0;
    mem_waddr = wr_addr_q;
    mem_wdata = acc_sum[AccBits] ? AccMax : acc_sum[AccBits-1:0];
    if (state_q == StClear) begin
      mem_we = 1'b1;
      mem_waddr = clr_q;
      mem_wdata = '0;
    end else if (wr_pend_q) begin
      mem_we = 1'b1;
    end
    mem_raddr = (state_q == StAcc) ? c_addr : rd_addr;
    fwd_d = wr_pend_q && (state_q == StAcc) && (c_addr == wr_addr_q);
  end

  cmd3_ram #(.Width(AccBits), .Depth(Cells)) u_grid (
    .clk_i, .we_i(mem_we), .waddr_i(mem_waddr), .wdata_i(mem_wdata),
    .raddr_i(mem_raddr), .rdata_o(mem_rdata)
  );

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = (state_q == StOut);
  assign m_axis_tdata  = out_q;

  logic [MAX_LEVEL-1:0] cx_d, cy_d, cz_d;
  logic [WB-1:0] dx_d, dy_d, dz_d;
  always_comb begin
    split(item_q[24:1],  org_x_q, lev_q, cx_d, dx_d);
    split(item_q[48:25], org_y_q, lev_q, cy_d, dy_d);
    split(item_q[72:49], org_z_q, lev_q, cz_d, dz_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StClear;
      clr_q     <= '0;
      org_x_q   <= '0;
      org_y_q   <= '0;
      org_z_q   <= '0;
      level_q   <= 3'd6;
      wr_pend_q <= 1'b0;
      fwd_q     <= 1'b0;
      rd_fwd_q  <= 1'b0;
      corner_q  <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_reg_e'(cfg_index_i))
          CfgOriginX: org_x_q <= cfg_data_i;
          CfgOriginY: org_y_q <= cfg_data_i;
          CfgOriginZ: org_z_q <= cfg_data_i;
          CfgLevel:   level_q <= cfg_data_i[2:0];
          default: ;
        endcase
      end
      wr_pend_q <= 1'b0;
      fwd_q <= fwd_d;
      if (wr_pend_q) last_wdata_q <= mem_wdata;
      case (state_q)
        StClear: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == GridBits'(Cells - 1)) state_q <= StIdle;
        end
        StIdle: begin
          if (s_axis_tvalid) begin
            item_q <= s_axis_tdata;
            lev_q  <= lev_use;
            rd_idx_q <= IdxBits'(rd_addr);
            rd_fwd_q <= wr_pend_q && (wr_addr_q == rd_addr);
            state_q <= (s_axis_tdata[0] == OpRead) ? StRdWait : StSplit;
          end
        end
        StSplit: begin
          cx_q <= cx_d; cy_q <= cy_d; cz_q <= cz_d;
          dx_q <= dx_d; dy_q <= dy_d; dz_q <= dz_d;
          state_q <= StWy;
        end
        StWy: begin
          wy_q[0] <= part_of(OneW - dx_q, OneW - dy_q);
          wy_q[1] <= (OneW - dx_q) - part_of(OneW - dx_q, OneW - dy_q);
          wy_q[2] <= part_of(dx_q, OneW - dy_q);
          wy_q[3] <= dx_q - part_of(dx_q, OneW - dy_q);
          state_q <= StWz;
        end
        StWz: begin
          for (int n = 0; n < 4; n++) begin
            wz_q[2*n]   <= part_of(wy_q[n], OneW - dz_q);
            wz_q[2*n+1] <= wy_q[n] - part_of(wy_q[n], OneW - dz_q);
          end
          corner_q <= '0;
          state_q <= StAcc;
        end
        StAcc: begin
          // Read this corner now; it is written back next cycle.
          wr_pend_q <= 1'b1;
          wr_addr_q <= c_addr;
          wr_w_q    <= wz_q[corner_q];
          corner_q  <= corner_q + 1'b1;
          if (corner_q == 3'd7) state_q <= StIdle;
        end
        StRdWait: state_q <= StOut;
        StOut: begin
          if (m_axis_tready) state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
      if (state_q == StRdWait) begin
        out_q <= {5'd0, (rd_data == AccMax), rd_data, rd_idx_q};
      end
    end
  end

  // The last corner write lands in the first idle cycle; a read accepted then
  // takes the written word from the forwarding register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StAcc && corner_q == 3'd7) |=> wr_pend_q && state_q == StIdle)
    else $error("last corner write lost");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input taken while output pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StClear) |-> !s_axis_tready && !m_axis_tvalid)
    else $error("activity during clear sweep");

endmodule
